// ===== rtl/core/mvfb_pkg.sv =====
// Shared types, constants and CRC function for the MAVLink v2 frame builder.
`default_nettype none
package mvfb_pkg;

  localparam logic [7:0]  STX_BYTE = 8'hFD;
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam int          HDR_LEN  = 10;
  localparam int          HDR_IDX_W = $clog2(HDR_LEN);

  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_PAYLOAD = 2'd1;
  localparam logic [1:0] ACT_FINISH  = 2'd2;

  localparam logic [7:0] REG_SYSTEM_ID    = 8'd0;
  localparam logic [7:0] REG_COMPONENT_ID = 8'd1;

  localparam logic [7:0] SYSTEM_ID_RESET    = 8'd1;
  localparam logic [7:0] COMPONENT_ID_RESET = 8'd1;

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // arg carries data_byte, msg_len or msg_extra depending on action
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  arg;
    logic [23:0] msg_id;
    logic [7:0]  seq;
  } cmd_t;

  // CRC-16/MCRF4XX, one byte
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mvfb_front.sv =====
// Front end: accepts items, drops unused codes, stamps the sequence number.
`default_nettype none
module mvfb_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic          q_full,
  input  wire logic [1:0]    action,
  input  wire logic [7:0]    data_byte,
  input  wire logic [23:0]   msg_id,
  input  wire logic [7:0]    msg_len,
  input  wire logic [7:0]    msg_extra,
  output logic               q_wr,
  output mvfb_pkg::cmd_t     q_cmd
);

  logic [7:0] seq;
  logic       accept;

  assign accept = push && !q_full;

  always_comb begin
    q_wr        = 1'b0;
    q_cmd.action = action;
    q_cmd.msg_id = msg_id;
    q_cmd.seq    = seq;
    q_cmd.arg    = data_byte;
    case (action)
      mvfb_pkg::ACT_START: begin
        q_wr      = accept;
        q_cmd.arg = msg_len;
      end
      mvfb_pkg::ACT_PAYLOAD: begin
        q_wr      = accept;
        q_cmd.arg = data_byte;
      end
      mvfb_pkg::ACT_FINISH: begin
        q_wr      = accept;
        q_cmd.arg = msg_extra;
      end
      default: begin
        q_wr = 1'b0;  // unused code: item taken, nothing queued
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= 8'd0;
    end else if (accept && action == mvfb_pkg::ACT_START) begin
      seq <= seq + 8'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mvfb_cmdq.sv =====
// Short command queue between front and back ends.
`default_nettype none
module mvfb_cmdq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr,
  input  wire mvfb_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          rd,
  output mvfb_pkg::cmd_t     rd_cmd,
  output logic               not_empty
);

  mvfb_pkg::cmd_t entries [mvfb_pkg::CMDQ_DEPTH];
  logic [mvfb_pkg::CMDQ_PTR_W-1:0] wr_ptr;
  logic [mvfb_pkg::CMDQ_PTR_W-1:0] rd_ptr;
  logic [mvfb_pkg::CMDQ_PTR_W:0]   count;
  logic do_wr;
  logic do_rd;

  assign full      = (count == (mvfb_pkg::CMDQ_PTR_W+1)'(mvfb_pkg::CMDQ_DEPTH));
  assign not_empty = (count != '0);
  assign do_wr     = wr && !full;
  assign do_rd     = rd && not_empty;
  assign rd_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mvfb_back.sv =====
// Back end: expands commands into frame bytes, runs the CRC, holds the output register.
`default_nettype none
module mvfb_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          q_valid,
  input  wire mvfb_pkg::cmd_t q_cmd,
  output logic               q_rd,
  output logic               empty,
  input  wire logic          pop,
  output logic [7:0]         frame_byte,
  output logic               last_of_run,
  output logic               frame_end
);

  logic [7:0]  system_id;
  logic [7:0]  component_id;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [mvfb_pkg::HDR_IDX_W-1:0] idx;
  logic [mvfb_pkg::HDR_IDX_W-1:0] idx_next;
  logic        out_valid;
  logic        out_ready;
  logic        step;
  logic [7:0]  byte_next;
  logic        last_next;
  logic        end_next;
  logic [7:0]  hdr_byte;
  logic [15:0] fin_crc;
  logic        hdr_last;

  assign out_ready = !out_valid || pop;
  assign step      = q_valid && out_ready;
  assign empty     = !out_valid;
  assign hdr_last  = (idx == mvfb_pkg::HDR_IDX_W'(mvfb_pkg::HDR_LEN - 1));
  assign fin_crc   = mvfb_pkg::crc_step(running_crc, q_cmd.arg);

  always_comb begin
    case (idx)
      4'd0:    hdr_byte = mvfb_pkg::STX_BYTE;
      4'd1:    hdr_byte = q_cmd.arg;
      4'd2:    hdr_byte = 8'h00;
      4'd3:    hdr_byte = 8'h00;
      4'd4:    hdr_byte = q_cmd.seq;
      4'd5:    hdr_byte = system_id;
      4'd6:    hdr_byte = component_id;
      4'd7:    hdr_byte = q_cmd.msg_id[7:0];
      4'd8:    hdr_byte = q_cmd.msg_id[15:8];
      4'd9:    hdr_byte = q_cmd.msg_id[23:16];
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    byte_next        = q_cmd.arg;
    last_next        = 1'b1;
    end_next         = 1'b0;
    q_rd             = 1'b0;
    idx_next         = idx;
    running_crc_next = running_crc;
    case (q_cmd.action)
      mvfb_pkg::ACT_START: begin
        byte_next = hdr_byte;
        last_next = hdr_last;
        // STX is not covered by the CRC; it reseeds instead
        running_crc_next = (idx == '0) ? mvfb_pkg::CRC_SEED
                                       : mvfb_pkg::crc_step(running_crc, hdr_byte);
        if (hdr_last) begin
          q_rd     = step;
          idx_next = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      mvfb_pkg::ACT_PAYLOAD: begin
        byte_next        = q_cmd.arg;
        running_crc_next = mvfb_pkg::crc_step(running_crc, q_cmd.arg);
        q_rd             = step;
      end
      mvfb_pkg::ACT_FINISH: begin
        if (idx == '0) begin
          byte_next        = fin_crc[7:0];
          last_next        = 1'b0;
          running_crc_next = fin_crc;
          idx_next         = idx + 1'b1;
        end else begin
          byte_next        = running_crc[15:8];
          end_next         = 1'b1;
          running_crc_next = mvfb_pkg::CRC_SEED;
          idx_next         = '0;
          q_rd             = step;
        end
      end
      default: begin
        q_rd = step;  // never queued; drain if seen
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      system_id    <= mvfb_pkg::SYSTEM_ID_RESET;
      component_id <= mvfb_pkg::COMPONENT_ID_RESET;
    end else if (cfg_wr) begin
      if (cfg_index == mvfb_pkg::REG_SYSTEM_ID) begin
        system_id <= cfg_data;
      end else if (cfg_index == mvfb_pkg::REG_COMPONENT_ID) begin
        component_id <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= mvfb_pkg::CRC_SEED;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        running_crc <= running_crc_next;
        idx         <= idx_next;
      end
      if (out_ready) begin
        out_valid <= step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_byte  <= byte_next;
      last_of_run <= last_next;
      frame_end   <= end_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mavlink_v2_frame_builder_top.sv =====
// An item's first byte goes through the command queue, then the output register.
// One result byte per cycle while the receiver pops; payload items sustain one
// per cycle, a start item expands to ten header bytes and a finish to two.
// A four-entry command queue lets the input side run ahead of the byte sequencer.
// Reset (rst, synchronous, active high) empties the queue and output register,
// clears the sequence number, sets the CRC to 0xFFFF and both id registers to 1.
`default_nettype none
module mavlink_v2_frame_builder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  data_byte,
  input  wire logic [23:0] msg_id,
  input  wire logic [7:0]  msg_len,
  input  wire logic [7:0]  msg_extra,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       frame_byte,
  output logic             last_of_run,
  output logic             frame_end
);

  logic           q_wr;
  mvfb_pkg::cmd_t q_wr_cmd;
  logic           q_rd;
  mvfb_pkg::cmd_t q_rd_cmd;
  logic           q_valid;

  assign cfg_ready = 1'b1;

  mvfb_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .q_full      (full),
    .action      (action),
    .data_byte   (data_byte),
    .msg_id      (msg_id),
    .msg_len     (msg_len),
    .msg_extra   (msg_extra),
    .q_wr        (q_wr),
    .q_cmd       (q_wr_cmd)
  );

  mvfb_cmdq u_cmdq (
    .clk       (clk),
    .rst       (rst),
    .wr        (q_wr),
    .wr_cmd    (q_wr_cmd),
    .full      (full),
    .rd        (q_rd),
    .rd_cmd    (q_rd_cmd),
    .not_empty (q_valid)
  );

  mvfb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_valid     (q_valid),
    .q_cmd       (q_rd_cmd),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .frame_byte  (frame_byte),
    .last_of_run (last_of_run),
    .frame_end   (frame_end)
  );

endmodule
`default_nettype wire

// ===== dv/mavlink_v2_frame_builder_top_tb.sv =====
// Self-checking testbench for the MAVLink v2 frame builder byte stream.
`timescale 1ns / 1ps
module mavlink_v2_frame_builder_top_tb;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_STALL = 300;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [23:0] msg_id;
    logic [7:0]  msg_len;
    logic [7:0]  msg_extra;
  } frame_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_run;
    logic       frame_end;
  } frame_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  action = '0;
  logic [7:0]  data_byte = '0;
  logic [23:0] msg_id = '0;
  logic [7:0]  msg_len = '0;
  logic [7:0]  msg_extra = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  frame_byte;
  logic        last_of_run;
  logic        frame_end;

  mavlink_v2_frame_builder_top u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .action(action),
    .data_byte(data_byte),
    .msg_id(msg_id),
    .msg_len(msg_len),
    .msg_extra(msg_extra),
    .empty(empty),
    .pop(pop),
    .frame_byte(frame_byte),
    .last_of_run(last_of_run),
    .frame_end(frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  sys_id = mvfb_pkg::SYSTEM_ID_RESET;
  logic [7:0]  comp_id = mvfb_pkg::COMPONENT_ID_RESET;
  logic [7:0]  seq_num = 8'h00;
  logic [15:0] crc_run = mvfb_pkg::CRC_SEED;

  frame_item_t stim_q[$];
  frame_out_t  frame_bytes_q[$];
  int          errors = 0;
  int          idle_cycles = 0;

  // handshake bookkeeping shared between edges
  logic push_fire = 1'b0;
  logic pop_fire = 1'b0;
  logic offering = 1'b0;
  int   tx_wait = 0;
  int   rx_wait = 0;
  logic tx_idle_on = 1'b1;
  logic rx_idle_on = 1'b1;
  int   rx_stall_len = 0;
  int   rx_stall_reqs = 0;
  int   rx_stall_seen = 0;
  int   rx_stall_left = 0;
  frame_item_t cur;

  // reflected CCITT, poly 0x8408: bitwise form of the MCRF4XX byte update
  function automatic logic [15:0] mcrf_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  task automatic predict_frame_bytes(input frame_item_t it);
    logic [7:0]  hdr [0:9];
    logic [15:0] crc;
    int i;
    case (it.action)
      mvfb_pkg::ACT_START: begin
        hdr = '{mvfb_pkg::STX_BYTE, it.msg_len, 8'h00, 8'h00, seq_num, sys_id, comp_id,
                it.msg_id[7:0], it.msg_id[15:8], it.msg_id[23:16]};
        crc = mvfb_pkg::CRC_SEED;
        for (i = 1; i < mvfb_pkg::HDR_LEN; i++) crc = mcrf_fold(crc, hdr[i]);
        for (i = 0; i < mvfb_pkg::HDR_LEN; i++)
          frame_bytes_q.push_back('{hdr[i], i == mvfb_pkg::HDR_LEN - 1, 1'b0});
        seq_num = seq_num + 8'd1;
        crc_run = crc;
      end
      mvfb_pkg::ACT_PAYLOAD: begin
        crc_run = mcrf_fold(crc_run, it.data_byte);
        frame_bytes_q.push_back('{it.data_byte, 1'b1, 1'b0});
      end
      mvfb_pkg::ACT_FINISH: begin
        crc = mcrf_fold(crc_run, it.msg_extra);
        frame_bytes_q.push_back('{crc[7:0], 1'b0, 1'b0});
        frame_bytes_q.push_back('{crc[15:8], 1'b1, 1'b1});
        crc_run = mvfb_pkg::CRC_SEED;
      end
      default: ;
    endcase
  endtask

  // sample side: predictor, checker, watchdog
  always @(posedge clk) begin
    frame_out_t want;
    if (rst) begin
      push_fire <= 1'b0;
      pop_fire <= 1'b0;
    end else begin
      push_fire <= push && !full;
      pop_fire <= pop && !empty;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mvfb_pkg::REG_SYSTEM_ID:    sys_id = cfg_data;
          mvfb_pkg::REG_COMPONENT_ID: comp_id = cfg_data;
          default: ;
        endcase
      end
      if (push && !full)
        predict_frame_bytes('{action, data_byte, msg_id, msg_len, msg_extra});
      if (pop && !empty) begin
        if (frame_bytes_q.size() == 0) begin
          $display("%0t: unexpected byte, expected none, got %02h", $time, frame_byte);
          errors++;
        end else begin
          want = frame_bytes_q.pop_front();
          if (frame_byte !== want.frame_byte) begin
            $display("%0t: frame_byte expected %02h, got %02h", $time, want.frame_byte,
                     frame_byte);
            errors++;
          end
          if (last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %0b, got %0b", $time, want.last_of_run,
                     last_of_run);
            errors++;
          end
          if (frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %0b, got %0b", $time, want.frame_end,
                     frame_end);
            errors++;
          end
        end
      end
      if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // item sender
  always @(negedge clk) begin
    if (!rst) begin
      if (push_fire) begin
        offering = 1'b0;
        tx_wait = tx_idle_on ? $urandom_range(0, 4) : 0;
      end
      if (!offering) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (stim_q.size() > 0) begin
          cur = stim_q.pop_front();
          offering = 1'b1;
          action <= cur.action;
          data_byte <= cur.data_byte;
          msg_id <= cur.msg_id;
          msg_len <= cur.msg_len;
          msg_extra <= cur.msg_extra;
        end
      end
      push <= offering;
    end
  end

  // byte receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (rx_stall_reqs != rx_stall_seen) begin
        rx_stall_seen = rx_stall_reqs;
        rx_stall_left = rx_stall_len;
      end
      if (pop_fire) rx_wait = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        pop <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  function automatic frame_item_t mk_item(input logic [1:0] act, input logic [7:0] d,
                                          input logic [23:0] m, input logic [7:0] len,
                                          input logic [7:0] extra);
    frame_item_t it;
    it.action = act;
    it.data_byte = d;
    it.msg_id = m;
    it.msg_len = len;
    it.msg_extra = extra;
    return it;
  endfunction

  function automatic frame_item_t rand_item(input logic [1:0] act);
    return mk_item(act, 8'($urandom_range(0, 255)), 24'($urandom()),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // start, payload run, finish; some frames carry a wrong length or stay open
  task automatic queue_frame();
    frame_item_t it;
    int n;
    int r;
    r = $urandom_range(0, 9);
    n = $urandom_range(0, 6);
    it = rand_item(mvfb_pkg::ACT_START);
    if (r < 7) it.msg_len = 8'(n);
    stim_q.push_back(it);
    repeat (n) stim_q.push_back(rand_item(mvfb_pkg::ACT_PAYLOAD));
    if (r != 9) stim_q.push_back(rand_item(mvfb_pkg::ACT_FINISH));
  endtask

  task automatic queue_random(input int n);
    int base;
    base = stim_q.size();
    while (stim_q.size() - base < n) begin
      if ($urandom_range(0, 4) == 0) stim_q.push_back(rand_item(2'($urandom_range(0, 3))));
      else queue_frame();
    end
  endtask

  task automatic wait_frames_drained();
    do @(negedge clk);
    while (stim_q.size() != 0 || offering || frame_bytes_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_ids(input logic [7:0] sys, input logic [7:0] comp);
    write_reg(mvfb_pkg::REG_SYSTEM_ID, sys);
    write_reg(mvfb_pkg::REG_COMPONENT_ID, comp);
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset ids, orphan payload and finish, extremes, unused code
    stim_q.push_back(mk_item(mvfb_pkg::ACT_PAYLOAD, 8'h00, 24'hFFFFFF, 8'hFF, 8'hFF));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_PAYLOAD, 8'hFF, 24'h000000, 8'h00, 8'h00));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_FINISH, 8'hFF, 24'hFFFFFF, 8'hFF, 8'h00));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_FINISH, 8'h00, 24'h000000, 8'h00, 8'hFF));
    stim_q.push_back(mk_item(ACT_UNUSED, 8'hFF, 24'hFFFFFF, 8'hFF, 8'hFF));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_START, 8'h00, 24'hFFFFFF, 8'hFF, 8'h00));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_PAYLOAD, 8'hFF, 24'h000000, 8'h00, 8'hFF));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_PAYLOAD, 8'h00, 24'hFFFFFF, 8'hFF, 8'hFF));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_FINISH, 8'h00, 24'h000000, 8'h00, 8'h00));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_START, 8'hFF, 24'h000000, 8'h00, 8'hFF));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_FINISH, 8'h00, 24'hFFFFFF, 8'hFF, 8'hFF));
    stim_q.push_back(mk_item(mvfb_pkg::ACT_START, 8'h5A, 24'h123456, 8'h03, 8'hA5));
    stim_q.push_back(rand_item(mvfb_pkg::ACT_PAYLOAD));
    stim_q.push_back(mk_item(ACT_UNUSED, 8'h00, 24'h000000, 8'h00, 8'h00));
    stim_q.push_back(rand_item(mvfb_pkg::ACT_PAYLOAD));
    stim_q.push_back(rand_item(mvfb_pkg::ACT_PAYLOAD));
    stim_q.push_back(rand_item(mvfb_pkg::ACT_FINISH));
    // restart while a frame is still open
    stim_q.push_back(rand_item(mvfb_pkg::ACT_START));
    stim_q.push_back(rand_item(mvfb_pkg::ACT_START));
    stim_q.push_back(rand_item(mvfb_pkg::ACT_FINISH));
    wait_frames_drained();

    set_ids(8'h00, 8'hFF);
    queue_random(20);
    wait_frames_drained();

    set_ids(8'hFF, 8'h00);
    queue_random(25);
    wait_frames_drained();

    // receiver holds off while headers pile up, so the input side must stall
    tx_idle_on = 1'b0;
    rx_stall_len = LONG_STALL;
    rx_stall_reqs++;
    repeat (16) stim_q.push_back(rand_item(mvfb_pkg::ACT_START));
    repeat (4) stim_q.push_back(rand_item(mvfb_pkg::ACT_PAYLOAD));
    wait_frames_drained();

    // back-to-back on both sides
    set_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    rx_idle_on = 1'b0;
    queue_random(30);
    wait_frames_drained();

    set_ids(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    queue_random(30);
    wait_frames_drained();

    if (frame_bytes_q.size() != 0) begin
      $display("%0t: %0d expected bytes never came", $time, frame_bytes_q.size());
      errors++;
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mvfb_pkg.sv
rtl/core/mvfb_front.sv
rtl/core/mvfb_cmdq.sv
rtl/core/mvfb_back.sv
rtl/core/mavlink_v2_frame_builder_top.sv
dv/mavlink_v2_frame_builder_top_tb.sv
